// File: sv/lfpd_pkg.sv
// Shared types and constants for the line-follow PD drive unit.
package lfpd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_POSITION  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED_LEFT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED_RIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOW_DIVISOR     = 3'd5;

   // Reset values of the configuration registers
   localparam logic signed [15:0] RST_TARGET_POSITION  = 16'sd0;
   localparam logic [7:0]         RST_PROP_GAIN        = 8'd40;
   localparam logic [7:0]         RST_DERIV_GAIN       = 8'd180;
   localparam logic [7:0]         RST_BASE_SPEED_LEFT  = 8'd255;
   localparam logic [7:0]         RST_BASE_SPEED_RIGHT = 8'd255;
   localparam logic [7:0]         RST_SLOW_DIVISOR     = 8'd1;

   // One quotient bit per divider step; quotients above 255 saturate
   localparam int DIV_STEPS  = 8;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic signed [15:0] target_position;
      logic [7:0]         prop_gain;
      logic [7:0]         deriv_gain;
      logic [7:0]         base_speed_left;
      logic [7:0]         base_speed_right;
      logic [7:0]         slow_divisor;
   } cfg_type;

   typedef enum logic [1:0] {
      DIV_LEFT,
      DIV_RIGHT,
      DIV_FINAL
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MULP,
      ST_MULD,
      ST_LOAD,
      ST_STEP,
      ST_STORE,
      ST_PREP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        diff;
      logic        mulp;
      logic        muld;
      logic        div_load;
      logic        div_step;
      logic        div_store;
      logic        prep;
      logic        publish;
      div_sel_type div_sel;
   } cmd_type;

   typedef struct packed {
      logic need_final;
   } status_type;

endpackage

// File: sv/lfpd_ctrl.sv
// Sequencer for the PD drive unit: handshakes, arithmetic phases and divider passes.
module lfpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lfpd_pkg::status_type status,
   output lfpd_pkg::cmd_type    cmd
);
   import lfpd_pkg::*;

   state_type                state_ff, state_in;
   div_sel_type              sel_ff, sel_in;
   logic [STEP_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= DIV_LEFT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MULP;
         end
         ST_MULP: begin
            cmd.mulp = 1'b1;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            cmd.muld = 1'b1;
            sel_in   = DIV_LEFT;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.div_store = 1'b1;
            case (sel_ff)
               DIV_LEFT: begin
                  sel_in   = DIV_RIGHT;
                  state_in = ST_LOAD;
               end
               DIV_RIGHT: begin
                  state_in = status.need_final ? ST_PREP : ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            sel_in   = DIV_FINAL;
            state_in = ST_LOAD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// File: sv/lfpd_datapath.sv
// Error, PD products, serial divider and result register of the drive unit.
module lfpd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lfpd_pkg::cfg_type     cfg,
   input  lfpd_pkg::cmd_type     cmd,
   output lfpd_pkg::status_type  status,
   input  logic signed [15:0]    req_position,
   input  logic [7:0]            req_sensors_on_line,
   output logic [7:0]            rsp_left_speed,
   output logic [7:0]            rsp_right_speed,
   output logic                  rsp_left_reverse,
   output logic                  rsp_right_reverse
);
   import lfpd_pkg::*;

   logic signed [16:0] err_ff, last_err_ff;
   logic signed [17:0] deriv_ff;
   logic signed [24:0] prod_ff, prod_in, pg_ext, err_ext;
   logic signed [26:0] drive_ff, drive_in, dg_ext, deriv_ext;
   logic               lost_ff;

   logic [7:0]  div_eff;
   logic [7:0]  qa_ff, qb_ff, qc_ff;
   logic signed [27:0] num, num_c_ff, num_c_in, drive_x, mag_x;
   logic        lrev_c_ff, lrev_c_in, rrev_c_ff, rrev_c_in;

   logic [15:0] rem_ff;
   logic [14:0] dsh_ff;
   logic [7:0]  quo_ff;
   logic        neg_ff, sat_ff;
   logic        fits;
   logic [7:0]  div_result;

   logic [7:0]  ls_ff, rs_ff, ls_in, rs_in;
   logic        lr_ff, rr_ff, lr_in, rr_in;

   // Products at full precision, operands extended to the result width
   assign pg_ext    = $signed({17'b0, cfg.prop_gain});
   assign err_ext   = {{8{err_ff[16]}}, err_ff};
   assign prod_in   = pg_ext * err_ext;
   assign dg_ext    = $signed({19'b0, cfg.deriv_gain});
   assign deriv_ext = {{9{deriv_ff[17]}}, deriv_ff};
   assign drive_in  = {{2{prod_ff[24]}}, prod_ff} + dg_ext * deriv_ext;

   assign div_eff = (cfg.slow_divisor == 8'd0) ? 8'd1 : cfg.slow_divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
      end else if (cmd.diff) begin
         last_err_ff <= err_ff;
      end
   end

   // Choose the dividend; line lost halves the base speeds first
   always_comb begin
      case (cmd.div_sel)
         DIV_LEFT:  num = $signed({20'b0, lost_ff ? {1'b0, cfg.base_speed_left[7:1]}
                                                   : cfg.base_speed_left});
         DIV_RIGHT: num = $signed({20'b0, lost_ff ? {1'b0, cfg.base_speed_right[7:1]}
                                                   : cfg.base_speed_right});
         default:   num = num_c_ff;
      endcase
   end

   // Steering numerator and reverse bit from the drive sign and base quotients
   assign drive_x = {drive_ff[26], drive_ff};
   assign mag_x   = -drive_x;
   always_comb begin
      num_c_in  = '0;
      lrev_c_in = 1'b0;
      rrev_c_in = 1'b0;
      if (drive_x < 0) begin
         if (mag_x >= $signed({20'b0, qb_ff})) begin
            rrev_c_in = 1'b1;
            num_c_in  = mag_x - $signed({20'b0, cfg.base_speed_right});
         end else begin
            num_c_in  = $signed({20'b0, cfg.base_speed_right}) + drive_x;
         end
      end else begin
         if (drive_x >= $signed({20'b0, qa_ff})) begin
            lrev_c_in = 1'b1;
            num_c_in  = drive_x - $signed({20'b0, cfg.base_speed_left});
         end else begin
            num_c_in  = $signed({20'b0, cfg.base_speed_left}) - drive_x;
         end
      end
   end

   assign fits       = rem_ff >= {1'b0, dsh_ff};
   assign div_result = neg_ff ? 8'd0 : (sat_ff ? 8'hFF : quo_ff);

   always_comb begin
      ls_in = qa_ff;
      rs_in = qb_ff;
      lr_in = 1'b0;
      rr_in = 1'b0;
      if (lost_ff) begin
         lr_in = 1'b1;
         rr_in = 1'b1;
      end else if (drive_ff < 0) begin
         rs_in = qc_ff;
         rr_in = rrev_c_ff;
      end else if (drive_ff != '0) begin
         ls_in = qc_ff;
         lr_in = lrev_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff  <= {cfg.target_position[15], cfg.target_position}
                    - {req_position[15], req_position};
         lost_ff <= (req_sensors_on_line == 8'd0);
      end
      if (cmd.diff) begin
         deriv_ff <= {err_ff[16], err_ff} - {last_err_ff[16], last_err_ff};
      end
      if (cmd.mulp) begin
         prod_ff <= prod_in;
      end
      if (cmd.muld) begin
         drive_ff <= drive_in;
      end
      if (cmd.prep) begin
         num_c_ff  <= num_c_in;
         lrev_c_ff <= lrev_c_in;
         rrev_c_ff <= rrev_c_in;
      end
      if (cmd.div_load) begin
         neg_ff <= num[27];
         sat_ff <= !num[27] && (num[26:0] >= {11'b0, div_eff, 8'b0});
         rem_ff <= num[15:0];
         dsh_ff <= {div_eff, 7'b0};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         if (fits) begin
            rem_ff <= rem_ff - {1'b0, dsh_ff};
         end
         quo_ff <= {quo_ff[6:0], fits};
         dsh_ff <= {1'b0, dsh_ff[14:1]};
      end
      if (cmd.div_store) begin
         case (cmd.div_sel)
            DIV_LEFT:  qa_ff <= div_result;
            DIV_RIGHT: qb_ff <= div_result;
            default:   qc_ff <= div_result;
         endcase
      end
      if (cmd.publish) begin
         ls_ff <= ls_in;
         rs_ff <= rs_in;
         lr_ff <= lr_in;
         rr_ff <= rr_in;
      end
   end

   assign status.need_final = !lost_ff && (drive_ff != '0);

   assign rsp_left_speed    = ls_ff;
   assign rsp_right_speed   = rs_ff;
   assign rsp_left_reverse  = lr_ff;
   assign rsp_right_reverse = rr_ff;

endmodule

// File: sv/line_follow_pd_drive_unit.sv
// Top level of the line-follow PD drive unit: registers, sequencer and datapath.
// Sequence: an accepted request passes through the difference and product phases,
//   then three divider passes, or two when the line is lost or the drive is zero.
// Throughput: a new request is taken only after the last response is published; the
//   serial divider yields one quotient bit per cycle; a finished response waits in its
//   output register while the next request is taken.
// Reset: synchronous, active high; clears the sequencer, the response valid, the
//   stored previous error, and loads the register defaults.
module line_follow_pd_drive_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [15:0]                   req_position,
   input  logic [7:0]                           req_sensors_on_line,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_left_speed,
   output logic [7:0]                           rsp_right_speed,
   output logic                                 rsp_left_reverse,
   output logic                                 rsp_right_reverse,
   input  logic                                 csr_wen,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lfpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // Register file: hold every value until written; ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_TARGET_POSITION:  cfg_in.target_position  = $signed(csr_wdata);
            REG_PROP_GAIN:        cfg_in.prop_gain        = csr_wdata[7:0];
            REG_DERIV_GAIN:       cfg_in.deriv_gain       = csr_wdata[7:0];
            REG_BASE_SPEED_LEFT:  cfg_in.base_speed_left  = csr_wdata[7:0];
            REG_BASE_SPEED_RIGHT: cfg_in.base_speed_right = csr_wdata[7:0];
            REG_SLOW_DIVISOR:     cfg_in.slow_divisor     = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_position  <= RST_TARGET_POSITION;
         cfg_ff.prop_gain        <= RST_PROP_GAIN;
         cfg_ff.deriv_gain       <= RST_DERIV_GAIN;
         cfg_ff.base_speed_left  <= RST_BASE_SPEED_LEFT;
         cfg_ff.base_speed_right <= RST_BASE_SPEED_RIGHT;
         cfg_ff.slow_divisor     <= RST_SLOW_DIVISOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer: take a request, step through error, products and divider passes,
   // then publish once the response register is free
   lfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: error and derivative, PD drive, divide speeds by the slow divisor,
   // clamp, and hold the response payload
   lfpd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd                 (cmd),
      .status              (status),
      .req_position        (req_position),
      .req_sensors_on_line (req_sensors_on_line),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_left_reverse    (rsp_left_reverse),
      .rsp_right_reverse   (rsp_right_reverse)
   );

   // Never overwrite a response that is still waiting to be taken
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_ready))
      else $error("response published over an untaken response");

   // A divider pass is a load, exactly eight steps, then a store
   a_div_pass: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> cmd.div_step ##7 cmd.div_step ##1 cmd.div_store)
      else $error("divider pass does not run eight steps");

   // A request accepted now cannot be answered in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !cmd.publish)
      else $error("response published straight after a request");

endmodule

// File: bench/lfpd_checker.sv
// Checker for the line-follow PD drive unit: mirrors the registers, predicts and compares.
module lfpd_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [15:0]               req_position,
   input  logic [7:0]                       req_sensors_on_line,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [7:0]                       rsp_left_speed,
   input  logic [7:0]                       rsp_right_speed,
   input  logic                             rsp_left_reverse,
   input  logic                             rsp_right_reverse,
   input  logic                             csr_wen,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               pending,
   output int                               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lfpd_pkg::*;

   typedef struct packed {
      logic [7:0] left_speed;
      logic [7:0] right_speed;
      logic       left_reverse;
      logic       right_reverse;
   } wheel_cmd_type;

   wheel_cmd_type      wheel_q[$];
   wheel_cmd_type      want;
   cfg_type            cfg;
   logic signed [16:0] prev_error = '0;
   logic signed [16:0] line_error;
   int                 mismatches = 0;

   function automatic logic [7:0] clamp_duty(input longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // Wheel command for one request, given the new and the previous position error
   function automatic wheel_cmd_type steer(input logic signed [16:0] error,
                                           input logic signed [16:0] last,
                                           input logic [7:0] on_line);
      longint        e, dif, kp, kd, drive, dv, bl, br, ls, rs;
      wheel_cmd_type w;
      e     = error;
      dif   = e - longint'(last);
      kp    = cfg.prop_gain;
      kd    = cfg.deriv_gain;
      bl    = cfg.base_speed_left;
      br    = cfg.base_speed_right;
      dv    = cfg.slow_divisor;
      drive = kp * e + kd * dif;
      if (dv == 0) dv = 1;
      w.left_reverse  = 1'b0;
      w.right_reverse = 1'b0;
      if (on_line == 8'd0) begin
         // line lost: back up on both wheels at half speed
         w.left_reverse  = 1'b1;
         w.right_reverse = 1'b1;
         ls = bl / (2 * dv);
         rs = br / (2 * dv);
      end else if (drive < 0) begin
         ls = bl / dv;
         if (-drive >= br / dv) begin
            w.right_reverse = 1'b1;
            rs = (-drive - br) / dv;
         end else begin
            rs = (br + drive) / dv;
         end
      end else if (drive > 0) begin
         rs = br / dv;
         if (drive >= bl / dv) begin
            w.left_reverse = 1'b1;
            ls = (drive - bl) / dv;
         end else begin
            ls = (bl - drive) / dv;
         end
      end else begin
         ls = bl / dv;
         rs = br / dv;
      end
      w.left_speed  = clamp_duty(ls);
      w.right_speed = clamp_duty(rs);
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wheel_q.delete();
         cfg.target_position  = RST_TARGET_POSITION;
         cfg.prop_gain        = RST_PROP_GAIN;
         cfg.deriv_gain       = RST_DERIV_GAIN;
         cfg.base_speed_left  = RST_BASE_SPEED_LEFT;
         cfg.base_speed_right = RST_BASE_SPEED_RIGHT;
         cfg.slow_divisor     = RST_SLOW_DIVISOR;
         prev_error           = '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_TARGET_POSITION:  cfg.target_position  = csr_wdata;
               REG_PROP_GAIN:        cfg.prop_gain        = csr_wdata[7:0];
               REG_DERIV_GAIN:       cfg.deriv_gain       = csr_wdata[7:0];
               REG_BASE_SPEED_LEFT:  cfg.base_speed_left  = csr_wdata[7:0];
               REG_BASE_SPEED_RIGHT: cfg.base_speed_right = csr_wdata[7:0];
               REG_SLOW_DIVISOR:     cfg.slow_divisor     = csr_wdata[7:0];
               default: ;
            endcase
         end
         // retire before predicting, so a response never meets its own request
         if (rsp_valid && rsp_ready) begin
            if (wheel_q.size() == 0) begin
               report_mismatch("response arrived with nothing expected");
            end else begin
               want = wheel_q.pop_front();
               if (rsp_left_speed !== want.left_speed)
                  report_mismatch($sformatf("left_speed got %0d expected %0d",
                                            rsp_left_speed, want.left_speed));
               if (rsp_right_speed !== want.right_speed)
                  report_mismatch($sformatf("right_speed got %0d expected %0d",
                                            rsp_right_speed, want.right_speed));
               if (rsp_left_reverse !== want.left_reverse)
                  report_mismatch($sformatf("left_reverse got %b expected %b",
                                            rsp_left_reverse, want.left_reverse));
               if (rsp_right_reverse !== want.right_reverse)
                  report_mismatch($sformatf("right_reverse got %b expected %b",
                                            rsp_right_reverse, want.right_reverse));
            end
         end
         if (req_valid && req_ready) begin
            line_error = {cfg.target_position[15], cfg.target_position}
                         - {req_position[15], req_position};
            wheel_q.push_back(steer(line_error, prev_error, req_sensors_on_line));
            prev_error = line_error;
         end
      end
      pending    <= wheel_q.size();
      fail_count <= mismatches;
   end

endmodule

// File: bench/tb_top.sv
// Testbench top: clock, reset, request and register stimulus, watchdog and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lfpd_pkg::*;

   localparam int IDLE_LIMIT      = 4000;  // cycles with no request or response moving
   localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off to back the unit up
   localparam int SETTLE_CYCLES   = 40;    // a little over the long-path latency
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 60;

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic signed [15:0]     req_position        = '0;
   logic [7:0]             req_sensors_on_line = '0;
   logic                   rsp_ready           = 1'b0;
   logic                   csr_wen             = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index           = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata           = '0;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [7:0]             rsp_left_speed;
   logic [7:0]             rsp_right_speed;
   logic                   rsp_left_reverse;
   logic                   rsp_right_reverse;

   int                     pending;
   int                     fail_count;
   int                     send_idle_pct  = 0;
   int                     recv_stall_pct = 0;
   int                     stall_kick     = 0;
   int                     stall_seen     = 0;
   int                     hold_left      = 0;
   int                     quiet_cycles   = 0;
   logic signed [15:0]     cur_target     = RST_TARGET_POSITION;

   line_follow_pd_drive_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_position        (req_position),
      .req_sensors_on_line (req_sensors_on_line),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_left_reverse    (rsp_left_reverse),
      .rsp_right_reverse   (rsp_right_reverse),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   lfpd_checker wheel_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_position        (req_position),
      .req_sensors_on_line (req_sensors_on_line),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_left_reverse    (rsp_left_reverse),
      .rsp_right_reverse   (rsp_right_reverse),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .pending             (pending),
      .fail_count          (fail_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: random back-pressure, or a long hold-off when the stimulus asks for one.
   // The hold-off is counted here so the sender keeps offering requests meanwhile.
   always @(posedge clock) begin
      if (stall_kick != stall_seen) begin
         stall_seen <= stall_kick;
         hold_left  <= HOLD_OFF_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: give up once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no request or response accepted for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request, with random idle cycles in front of it, and hold it until taken
   task automatic send_request(input logic signed [15:0] pos, input logic [7:0] on_line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_position        <= pos;
      req_sensors_on_line <= on_line;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every expected response has been taken.
   // The first edge lets the checker's count catch up with the last request.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all six registers back to back; junk in the upper byte of the 8-bit ones
   task automatic apply_config(input cfg_type c);
      csr_wen <= 1'b1;
      put_reg(REG_TARGET_POSITION, c.target_position);
      put_reg(REG_PROP_GAIN, {8'($urandom()), c.prop_gain});
      put_reg(REG_DERIV_GAIN, {8'($urandom()), c.deriv_gain});
      put_reg(REG_BASE_SPEED_LEFT, {8'($urandom()), c.base_speed_left});
      put_reg(REG_BASE_SPEED_RIGHT, {8'($urandom()), c.base_speed_right});
      put_reg(REG_SLOW_DIVISOR, {8'($urandom()), c.slow_divisor});
      csr_wen    <= 1'b0;
      cur_target = c.target_position;
   endtask

   // Idle modes: none, sender mostly idle, receiver mostly stalling, both lightly
   task automatic set_idle(input int mode);
      case (mode)
         1:       begin send_idle_pct = 87; recv_stall_pct <= 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct <= 87; end
         3:       begin send_idle_pct = 10; recv_stall_pct <= 10; end
         default: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      endcase
   endtask

   // Register settings: small gains (steering branches), fully random, the extremes,
   // and moderate gains with a modest divisor
   function automatic cfg_type pick_config(input int kind, input bit low_end);
      cfg_type c;
      c.target_position  = 16'($urandom());
      c.prop_gain        = 8'($urandom());
      c.deriv_gain       = 8'($urandom());
      c.base_speed_left  = 8'($urandom());
      c.base_speed_right = 8'($urandom());
      c.slow_divisor     = 8'($urandom());
      case (kind)
         0: begin
            c.prop_gain    = 8'($urandom_range(3));
            c.deriv_gain   = 8'($urandom_range(3));
            c.slow_divisor = 8'($urandom_range(4));
         end
         1: ;
         2: begin
            c.target_position  = low_end ? 16'sh8000 : 16'sh7FFF;
            c.prop_gain        = low_end ? 8'd0 : 8'd255;
            c.deriv_gain       = low_end ? 8'd0 : 8'd255;
            c.base_speed_left  = low_end ? 8'd0 : 8'd255;
            c.base_speed_right = low_end ? 8'd0 : 8'd255;
            c.slow_divisor     = low_end ? 8'd0 : 8'd255;
         end
         default: begin
            c.prop_gain    = 8'($urandom_range(15));
            c.deriv_gain   = 8'($urandom_range(15));
            c.slow_divisor = 8'($urandom_range(1, 8));
         end
      endcase
      return c;
   endfunction

   // Mostly close to the target so the drive stays small, some anywhere, a few at the rails
   function automatic logic signed [15:0] next_position();
      int r;
      r = $urandom_range(99);
      if (r < 35) return cur_target + 16'($urandom_range(6)) - 16'sd3;
      if (r < 70) return cur_target + 16'($urandom_range(120)) - 16'sd60;
      if (r < 90) return 16'($urandom());
      return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
   endfunction

   function automatic logic [7:0] next_on_line();
      int r;
      r = $urandom_range(99);
      if (r < 15) return 8'd0;
      if (r < 25) return 8'd255;
      return 8'($urandom_range(1, 254));
   endfunction

   initial begin
      cfg_type c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: straight run, line lost, both hard turns, the position rails
      send_request(16'sd0, 8'd5);
      send_request(16'sd0, 8'd0);
      send_request(16'sh7FFF, 8'd1);
      send_request(16'sh8000, 8'd255);
      send_request(16'sh8000, 8'd0);
      send_request(16'sd0, 8'd128);
      send_request(16'sd1, 8'd1);
      send_request(-16'sd1, 8'd1);
      send_request(16'sd0, 8'd1);
      drain();

      // Every register at its top value: largest error swings and the largest divisor
      c = pick_config(2, 1'b0);
      apply_config(c);
      send_request(16'sh8000, 8'd255);
      send_request(16'sh7FFF, 8'd1);
      send_request(16'sh8000, 8'd0);
      drain();

      // Gentle gains and a zero divisor (taken as one): both soft turns, a hard turn whose
      // speed goes negative, and a zero drive
      c.target_position  = 16'sd100;
      c.prop_gain        = 8'd1;
      c.deriv_gain       = 8'd0;
      c.base_speed_left  = 8'd200;
      c.base_speed_right = 8'd90;
      c.slow_divisor     = 8'd0;
      apply_config(c);
      send_request(16'sd100, 8'd3);
      send_request(16'sd97, 8'd3);
      send_request(16'sd103, 8'd3);
      send_request(16'sd200, 8'd3);
      send_request(16'sd0, 8'd3);
      send_request(16'sd60, 8'd3);
      drain();

      // Random phases: settings and idle modes change between them, never mid-phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_idle((p / 2) % 4);
         apply_config(pick_config(p % 4, p >= 4));
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // hold the receiver off while requests keep coming, so the unit backs up
            if (p == 4 && n == 20) stall_kick <= stall_kick + 1;
            // pause the sender until every response is in, then carry on
            if (p == 5 && n == 30) drain();
            send_request(next_position(), next_on_line());
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
sv/lfpd_pkg.sv
sv/lfpd_ctrl.sv
sv/lfpd_datapath.sv
sv/line_follow_pd_drive_unit.sv
bench/lfpd_checker.sv
bench/tb_top.sv
